/* rtl/rmd_pkg.sv */
// Shared types and constants for the relay max-on and restart-delay supervisor.
// No dependencies; the top level, rmd_cfg_regs and rmd_core import this package.
`timescale 1ns / 1ps
package rmd_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int NOW_W         = 32;
	localparam int SEC_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int MS_PER_S      = 1000;
	// widest product of a 16-bit seconds value and MS_PER_S
	localparam int LIMIT_W       = 26;

	localparam logic [CFG_IDX_W-1:0] REG_BOOT_STATE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESTART_DELAY_S = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ON_S        = 2'd2;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SET  = 2'd1,
		OP_STOP = 2'd2,
		OP_INIT = 2'd3
	} op_t;

	typedef struct packed {
		logic             boot_state;
		logic [SEC_W-1:0] restart_delay_s;
		logic [SEC_W-1:0] max_on_s;
	} cfg_t;

	typedef struct packed {
		logic relay_on;
		logic drive_update;
		logic manual_notice;
		logic force_stop_notice;
		logic emergency_latched;
		logic delay_armed;
	} res_t;

endpackage

/* rtl/relay_max_on_and_restart_delay_top.sv */
// Top level of the relay supervisor: input stage, update core, result register.
// Depends on rmd_pkg, rmd_cfg_regs and rmd_core.
//
// Usage:
//   Command channel (cmd_valid/cmd_ready) carries opcode, now_ms, turn_on and
//   manual. Result channel (res_valid/res_ready) returns one item per command
//   with the relay state and the notice flags. Configuration is written through
//   cfg_we/cfg_index/cfg_wdata while no command is in flight; there is no
//   read-back and writes to an unused index are dropped.
//   A command accepted into the input register moves into the result register
//   once that register is free. Throughput is one item per cycle while the
//   receiver takes results: the whole update is one pass of compares and adds
//   between the input register and the result register, and the supervisor
//   state is updated as the item moves into the result register.
//   When the receiver stalls, the result register holds its item and the input
//   register still takes one more command; cmd_ready drops only when both are
//   full. Reset clears both stages, the relay state (off), the timers, the
//   emergency latch and the configuration registers.
`timescale 1ns / 1ps
module relay_max_on_and_restart_delay_top #(
	parameter int TIME_BITS = rmd_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  logic [1:0]                     opcode,
	input  logic [rmd_pkg::NOW_W-1:0]      now_ms,
	input  logic                           turn_on,
	input  logic                           manual,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic                           relay_on,
	output logic                           drive_update,
	output logic                           manual_notice,
	output logic                           force_stop_notice,
	output logic                           emergency_latched,
	output logic                           delay_armed,
	input  logic                           cfg_we,
	input  logic [rmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rmd_pkg::*;

	cfg_t             cfg;
	res_t             res_next;
	res_t             res_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic [1:0]       opcode_s1;
	logic [NOW_W-1:0] now_s1;
	logic             turn_on_s1;
	logic             manual_s1;
	logic             s2_free;
	logic             advance;

	assign s2_free   = !valid_s2 || res_ready;
	assign advance   = valid_s1 && s2_free;
	assign cmd_ready = !valid_s1 || s2_free;

	rmd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			opcode_s1  <= opcode;
			now_s1     <= now_ms;
			turn_on_s1 <= turn_on;
			manual_s1  <= manual;
		end
	end

	rmd_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.opcode  (opcode_s1),
		.now_ms  (now_s1),
		.turn_on (turn_on_s1),
		.manual  (manual_s1),
		.cfg     (cfg),
		.res     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign res_valid         = valid_s2;
	assign relay_on          = res_s2.relay_on;
	assign drive_update      = res_s2.drive_update;
	assign manual_notice     = res_s2.manual_notice;
	assign force_stop_notice = res_s2.force_stop_notice;
	assign emergency_latched = res_s2.emergency_latched;
	assign delay_armed       = res_s2.delay_armed;

endmodule

/* rtl/rmd_cfg_regs.sv */
// Configuration register file: boot state, restart delay and max on-time.
// Depends on rmd_pkg.
`timescale 1ns / 1ps
module rmd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rmd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output rmd_pkg::cfg_t                  cfg
);
	import rmd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOOT_STATE:      cfg_q.boot_state      <= cfg_wdata[0];
				REG_RESTART_DELAY_S: cfg_q.restart_delay_s <= cfg_wdata[SEC_W-1:0];
				REG_MAX_ON_S:        cfg_q.max_on_s        <= cfg_wdata[SEC_W-1:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/rmd_core.sv */
// Supervisor state and the single-pass update for one item.
// Depends on rmd_pkg; fed from the input stage of the top level.
`timescale 1ns / 1ps
module rmd_core #(
	parameter int TIME_BITS = rmd_pkg::TIME_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [1:0]                opcode,
	input  logic [rmd_pkg::NOW_W-1:0] now_ms,
	input  logic                      turn_on,
	input  logic                      manual,
	input  rmd_pkg::cfg_t             cfg,
	output rmd_pkg::res_t             res
);
	import rmd_pkg::*;

	localparam int CW = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

	logic                 relay_q;
	logic [TIME_BITS-1:0] on_since_q;
	logic                 pending_q;
	logic [TIME_BITS-1:0] deadline_q;
	logic                 latch_q;

	logic                 relay_d;
	logic [TIME_BITS-1:0] on_since_d;
	logic                 pending_d;
	logic [TIME_BITS-1:0] deadline_d;
	logic                 latch_d;
	logic                 drive;
	logic                 man_note;
	logic                 force_note;

	op_t                  op;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] elapsed;
	logic [CW-1:0]        on_limit;
	logic [CW-1:0]        arm_sum;
	logic                 over_limit;

	assign op       = op_t'(opcode);
	assign now_t    = TIME_BITS'(now_ms);
	assign elapsed  = now_t - on_since_q;
	assign on_limit = CW'(cfg.max_on_s) * CW'(MS_PER_S);
	assign arm_sum  = CW'(now_t) + CW'(cfg.restart_delay_s) * CW'(MS_PER_S);
	assign over_limit = relay_q && (cfg.max_on_s != '0) && (on_since_q != '0)
		&& (CW'(elapsed) > on_limit);

	always_comb begin
		relay_d    = relay_q;
		on_since_d = on_since_q;
		pending_d  = pending_q;
		deadline_d = deadline_q;
		latch_d    = latch_q;
		drive      = 1'b0;
		man_note   = 1'b0;
		force_note = 1'b0;
		unique case (op)
			OP_TICK: begin
				// relay is on here, so the forced stop always changes state
				if (over_limit) begin
					man_note   = 1'b1;
					pending_d  = 1'b0;
					relay_d    = 1'b0;
					drive      = 1'b1;
					on_since_d = '0;
					latch_d    = 1'b1;
					force_note = 1'b1;
				end
				if (pending_d && (now_t >= deadline_q)) begin
					pending_d = 1'b0;
					if (!relay_d) begin
						man_note   = 1'b1;
						relay_d    = 1'b1;
						drive      = 1'b1;
						latch_d    = 1'b0;
						on_since_d = now_t;
					end
				end
				if (!relay_d && !pending_d && (cfg.restart_delay_s != '0)) begin
					pending_d  = 1'b1;
					deadline_d = arm_sum[TIME_BITS-1:0];
				end
			end
			OP_SET: begin
				if (manual) begin
					man_note  = 1'b1;
					pending_d = 1'b0;
				end
				if (relay_q != turn_on) begin
					relay_d = turn_on;
					drive   = 1'b1;
					if (turn_on) begin
						latch_d    = 1'b0;
						on_since_d = now_t;
					end else begin
						on_since_d = '0;
					end
				end
			end
			OP_STOP: begin
				man_note  = 1'b1;
				pending_d = 1'b0;
				if (relay_q) begin
					relay_d    = 1'b0;
					drive      = 1'b1;
					on_since_d = '0;
				end
				latch_d    = 1'b1;
				force_note = 1'b1;
			end
			OP_INIT: begin
				pending_d  = 1'b0;
				deadline_d = '0;
				latch_d    = 1'b0;
				relay_d    = cfg.boot_state;
				on_since_d = cfg.boot_state ? now_t : '0;
				drive      = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q    <= 1'b0;
			on_since_q <= '0;
			pending_q  <= 1'b0;
			deadline_q <= '0;
			latch_q    <= 1'b0;
		end else if (advance) begin
			relay_q    <= relay_d;
			on_since_q <= on_since_d;
			pending_q  <= pending_d;
			deadline_q <= deadline_d;
			latch_q    <= latch_d;
		end
	end

	always_comb begin
		res.relay_on          = relay_d;
		res.drive_update      = drive;
		res.manual_notice     = man_note;
		res.force_stop_notice = force_note;
		res.emergency_latched = latch_d;
		res.delay_armed       = pending_d;
	end

endmodule

/* rtl/rmd_checker.sv */
// Port-level checks for the relay supervisor, bound to the top level.
// Depends on relay_max_on_and_restart_delay_top.
`timescale 1ns / 1ps
module rmd_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic relay_on,
	input logic drive_update,
	input logic manual_notice,
	input logic force_stop_notice,
	input logic emergency_latched,
	input logic delay_armed
);

	// hold a stalled result item
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(relay_on)
		&& $stable(drive_update) && $stable(manual_notice)
		&& $stable(force_stop_notice) && $stable(emergency_latched)
		&& $stable(delay_armed))
		else $error("result item changed while stalled");

	// a forced stop leaves the relay off, latched, and counts as manual;
	// a tick may re-arm the restart delay right after its forced stop
	a_force_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && force_stop_notice |-> !relay_on && emergency_latched
		&& manual_notice)
		else $error("forced stop left inconsistent state");

	// the emergency latch is only set with the relay off, and turning on clears it
	a_latch_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && relay_on |-> !emergency_latched)
		else $error("relay on while emergency latched");

endmodule

bind relay_max_on_and_restart_delay_top rmd_checker u_rmd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (res_valid),
	.res_ready         (res_ready),
	.relay_on          (relay_on),
	.drive_update      (drive_update),
	.manual_notice     (manual_notice),
	.force_stop_notice (force_stop_notice),
	.emergency_latched (emergency_latched),
	.delay_armed       (delay_armed)
);
